@@ hdl/brpm_pkg.sv @@
// Shared types and constants of the block ring pointer manager.
package brpm_pkg;

    localparam int unsigned MAX_BLOCKS      = 256;
    localparam int unsigned MAX_BLOCK_BYTES = 4096;

    localparam int unsigned BC_W   = 9;
    localparam int unsigned BS_W   = 13;
    localparam int unsigned IDX_W  = 8;
    localparam int unsigned FILL_W = 11;
    localparam int unsigned VAL_W  = 12;
    localparam int unsigned ADDR_W = 20;
    localparam int unsigned TOT_W  = 32;
    localparam int unsigned PADDR_W = 3;

    localparam logic [BC_W-1:0] BC_MAX    = BC_W'(MAX_BLOCKS);
    localparam logic [BS_W-1:0] BS_MAX    = BS_W'(MAX_BLOCK_BYTES);
    localparam logic [BC_W-1:0] BC_RESET  = BC_W'(256);
    localparam logic [BS_W-1:0] BS_RESET  = BS_W'(512);
    localparam logic signed [VAL_W-1:0] FILL_HI = VAL_W'(2 * MAX_BLOCKS);
    localparam logic signed [VAL_W-1:0] FILL_LO = -VAL_W'(2 * MAX_BLOCKS);

    typedef enum logic [1:0] {
        MODE_QUERY   = 2'd0,
        MODE_WRITE   = 2'd1,
        MODE_READ    = 2'd2,
        MODE_CLEAR   = 2'd3
    } mode_t;

    typedef enum logic {
        REG_BLOCK_COUNT = 1'b0,
        REG_BLOCK_SIZE  = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [BC_W-1:0] block_count;
        logic [BS_W-1:0] block_size;
    } cfg_t;

    typedef struct packed {
        logic [1:0]      mode;
        logic [BC_W-1:0] count;
        logic            blocking;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]         write_index;
        logic [IDX_W-1:0]         read_index;
        logic signed [FILL_W-1:0] fill_level;
        logic [BC_W-1:0]          write_hold;
        logic [BC_W-1:0]          read_hold;
        logic [TOT_W-1:0]         overflow_sum;
        logic [TOT_W-1:0]         underflow_sum;
    } ring_state_t;

endpackage

@@ hdl/brpm_regs.sv @@
// Configuration register bank with its APB-style access port.
module brpm_regs
    import brpm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg,
    output logic               cfg_clear
);

    logic [BC_W-1:0] block_count_reg;
    logic [BC_W-1:0] block_count_next;
    logic [BS_W-1:0] block_size_reg;
    logic [BS_W-1:0] block_size_next;
    logic            wr_en;
    logic [BC_W-1:0] bc_raw;
    logic [BS_W-1:0] bs_raw;
    reg_index_t      sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel    = reg_index_t'(paddr[2]);
    assign bc_raw = pwdata[BC_W-1:0];
    assign bs_raw = pwdata[BS_W-1:0];

    // A write of zero is dropped and leaves all state alone.
    always_comb
    begin
        block_count_next = block_count_reg;
        block_size_next  = block_size_reg;
        cfg_clear        = 1'b0;
        if (wr_en)
        begin
            unique case (sel)
                REG_BLOCK_COUNT:
                begin
                    if (bc_raw != '0)
                    begin
                        block_count_next = (bc_raw > BC_MAX) ? BC_MAX : bc_raw;
                        cfg_clear        = 1'b1;
                    end
                end
                REG_BLOCK_SIZE:
                begin
                    if (bs_raw != '0)
                    begin
                        block_size_next = (bs_raw > BS_MAX) ? BS_MAX : bs_raw;
                        cfg_clear       = 1'b1;
                    end
                end
                default:
                begin
                    cfg_clear = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= BC_RESET;
            block_size_reg  <= BS_RESET;
        end
        else
        begin
            block_count_reg <= block_count_next;
            block_size_reg  <= block_size_next;
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_BLOCK_COUNT: prdata = {{(32-BC_W){1'b0}}, block_count_reg};
            REG_BLOCK_SIZE:  prdata = {{(32-BS_W){1'b0}}, block_size_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.block_count = block_count_reg;
    assign cfg.block_size  = block_size_reg;

endmodule

@@ hdl/brpm_core.sv @@
// Command register and ring state update: indices, fill level, holds and totals.
module brpm_core
    import brpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_load,
    input  cmd_t        cmd_in,
    input  cfg_t        cfg,
    input  logic        cfg_clear,
    output ring_state_t st,
    output logic        upd_valid
);

    cmd_t        cmd_reg;
    logic        cmd_valid_reg;
    ring_state_t st_reg;
    ring_state_t st_next;
    logic        upd_valid_reg;

    logic [BC_W-1:0]           n;
    logic [BC_W-1:0]           hold;
    logic signed [VAL_W-1:0]   n_ext;
    logic signed [VAL_W-1:0]   fill_ext;
    logic signed [VAL_W-1:0]   free_read;
    logic signed [VAL_W-1:0]   free_write;
    logic signed [VAL_W-1:0]   fill_up;
    logic signed [VAL_W-1:0]   fill_dn;
    logic signed [VAL_W-1:0]   short_w;
    logic signed [VAL_W-1:0]   short_r;
    logic [BC_W-1:0]           wsum;
    logic [BC_W-1:0]           rsum;
    logic [TOT_W:0]            ovf_sum;
    logic [TOT_W:0]            unf_sum;

    always_comb
    begin
        n        = (cmd_reg.count > cfg.block_count) ? cfg.block_count : cmd_reg.count;
        hold     = cmd_reg.blocking ? n : '0;
        n_ext    = $signed({{(VAL_W-BC_W){1'b0}}, n});
        fill_ext = {{(VAL_W-FILL_W){st_reg.fill_level[FILL_W-1]}}, st_reg.fill_level};
        free_read  = fill_ext - $signed({{(VAL_W-BC_W){1'b0}}, st_reg.write_hold});
        free_write = $signed({{(VAL_W-BC_W){1'b0}}, cfg.block_count}) - fill_ext
                     - $signed({{(VAL_W-BC_W){1'b0}}, st_reg.read_hold});
        fill_up  = fill_ext + n_ext;
        fill_dn  = fill_ext - n_ext;
        short_w  = n_ext - free_write;
        short_r  = n_ext - free_read;
        // Indices stay below block_count and counts are clamped to it, so
        // one subtraction always wraps correctly.
        wsum     = {1'b0, st_reg.write_index} + n;
        rsum     = {1'b0, st_reg.read_index} + n;
        // A shortfall never exceeds 1024, so eleven bits carry it.
        ovf_sum  = {1'b0, st_reg.overflow_sum}
                   + {{(TOT_W+1-(FILL_W)){1'b0}}, short_w[FILL_W-1:0]};
        unf_sum  = {1'b0, st_reg.underflow_sum}
                   + {{(TOT_W+1-(FILL_W)){1'b0}}, short_r[FILL_W-1:0]};
    end

    // The hold sum always equals the last hold: it starts at zero and each
    // advance replaces it with max(0, sum - last) + hold, where sum == last.
    always_comb
    begin
        st_next = st_reg;
        if (cmd_valid_reg)
        begin
            unique case (mode_t'(cmd_reg.mode))
                MODE_QUERY:
                begin
                    st_next = st_reg;
                end
                MODE_WRITE:
                begin
                    if (free_write < n_ext)
                    begin
                        st_next.overflow_sum = ovf_sum[TOT_W] ? '1 : ovf_sum[TOT_W-1:0];
                    end
                    st_next.write_hold  = hold;
                    st_next.write_index = (wsum >= cfg.block_count)
                                          ? IDX_W'(wsum - cfg.block_count)
                                          : wsum[IDX_W-1:0];
                    st_next.fill_level  = (fill_up > FILL_HI) ? FILL_HI[FILL_W-1:0]
                                                              : fill_up[FILL_W-1:0];
                end
                MODE_READ:
                begin
                    if (free_read < n_ext)
                    begin
                        st_next.underflow_sum = unf_sum[TOT_W] ? '1 : unf_sum[TOT_W-1:0];
                    end
                    st_next.read_hold  = hold;
                    st_next.read_index = (rsum >= cfg.block_count)
                                         ? IDX_W'(rsum - cfg.block_count)
                                         : rsum[IDX_W-1:0];
                    st_next.fill_level = (fill_dn < FILL_LO) ? FILL_LO[FILL_W-1:0]
                                                             : fill_dn[FILL_W-1:0];
                end
                MODE_CLEAR:
                begin
                    st_next.read_index = st_reg.write_index;
                    st_next.fill_level = '0;
                    st_next.write_hold = '0;
                    st_next.read_hold  = '0;
                end
                default:
                begin
                    st_next = st_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_load)
        begin
            cmd_reg <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            upd_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            cmd_valid_reg <= cmd_load;
            upd_valid_reg <= cmd_valid_reg;
            if (cfg_clear)
            begin
                st_reg <= '0;
            end
            else
            begin
                st_reg <= st_next;
            end
        end
    end

    assign st        = st_reg;
    assign upd_valid = upd_valid_reg;

endmodule

@@ hdl/brpm_result.sv @@
// Result stage: byte addresses, free and contiguous counts, totals.
module brpm_result
    import brpm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     upd_valid,
    input  ring_state_t              st,
    input  cfg_t                     cfg,
    output logic                     done,
    output logic [ADDR_W-1:0]        write_address,
    output logic [ADDR_W-1:0]        read_address,
    output logic signed [VAL_W-1:0]  free_to_read,
    output logic signed [VAL_W-1:0]  free_to_write,
    output logic signed [VAL_W-1:0]  contiguous_read,
    output logic signed [VAL_W-1:0]  contiguous_write,
    output logic [TOT_W-1:0]         overflow_total,
    output logic [TOT_W-1:0]         underflow_total
);

    localparam int unsigned PROD_W = IDX_W + BS_W;

    logic                     done_reg;
    logic [ADDR_W-1:0]        waddr_reg;
    logic [ADDR_W-1:0]        raddr_reg;
    logic signed [VAL_W-1:0]  fr_reg;
    logic signed [VAL_W-1:0]  fw_reg;
    logic signed [VAL_W-1:0]  cr_reg;
    logic signed [VAL_W-1:0]  cw_reg;
    logic [TOT_W-1:0]         ovf_reg;
    logic [TOT_W-1:0]         unf_reg;

    logic [PROD_W-1:0]        wprod;
    logic [PROD_W-1:0]        rprod;
    logic signed [VAL_W-1:0]  bc_ext;
    logic signed [VAL_W-1:0]  fill_ext;
    logic signed [VAL_W-1:0]  fr;
    logic signed [VAL_W-1:0]  fw;
    logic signed [VAL_W-1:0]  to_end_r;
    logic signed [VAL_W-1:0]  to_end_w;

    // All values stay well inside -1024..1024, so no output clamp is needed.
    always_comb
    begin
        wprod    = {{BS_W{1'b0}}, st.write_index} * {{IDX_W{1'b0}}, cfg.block_size};
        rprod    = {{BS_W{1'b0}}, st.read_index} * {{IDX_W{1'b0}}, cfg.block_size};
        bc_ext   = $signed({{(VAL_W-BC_W){1'b0}}, cfg.block_count});
        fill_ext = {{(VAL_W-FILL_W){st.fill_level[FILL_W-1]}}, st.fill_level};
        fr       = fill_ext - $signed({{(VAL_W-BC_W){1'b0}}, st.write_hold});
        fw       = bc_ext - fill_ext - $signed({{(VAL_W-BC_W){1'b0}}, st.read_hold});
        to_end_r = bc_ext - $signed({{(VAL_W-IDX_W){1'b0}}, st.read_index});
        to_end_w = bc_ext - $signed({{(VAL_W-IDX_W){1'b0}}, st.write_index});
    end

    always_ff @(posedge clk)
    begin
        waddr_reg <= wprod[ADDR_W-1:0];
        raddr_reg <= rprod[ADDR_W-1:0];
        fr_reg    <= fr;
        fw_reg    <= fw;
        cr_reg    <= (fr < to_end_r) ? fr : to_end_r;
        cw_reg    <= (fw < to_end_w) ? fw : to_end_w;
        ovf_reg   <= st.overflow_sum;
        unf_reg   <= st.underflow_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= upd_valid;
        end
    end

    assign done             = done_reg;
    assign write_address    = waddr_reg;
    assign read_address     = raddr_reg;
    assign free_to_read     = fr_reg;
    assign free_to_write    = fw_reg;
    assign contiguous_read  = cr_reg;
    assign contiguous_write = cw_reg;
    assign overflow_total   = ovf_reg;
    assign underflow_total  = unf_reg;

endmodule

@@ hdl/block_ring_pointer_manager.sv @@
// Top level of the block ring pointer manager.
//
// Usage: a request (mode, count, blocking) is taken at a rising edge where
// start is high and busy is low. busy is never raised, so one request can be
// issued every cycle. Each request yields exactly one result, shown on the
// result ports for one cycle while done is high; the receiver must take it.
// A request passes the input register, the state update register and the
// result register before its result is presented. Throughput is one
// request per cycle; the state update is one add-and-compare pass.
// Results describe the ring state after their own request, in request order.
// Configuration: block_count at byte address 0, block_size at address 4,
// through the APB-style port; a nonzero write sets the register (saturated
// to its maximum) and resets indices, fill, holds and totals. The user is to
// make writes only when no request is in flight; no logic enforces this.
// Reset: block_count 256, block_size 512, all ring state zero, no result
// pending.
module block_ring_pointer_manager
    import brpm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               mode,
    input  logic [BC_W-1:0]          count,
    input  logic                     blocking,
    output logic                     done,
    output logic [ADDR_W-1:0]        write_address,
    output logic [ADDR_W-1:0]        read_address,
    output logic signed [VAL_W-1:0]  free_to_read,
    output logic signed [VAL_W-1:0]  free_to_write,
    output logic signed [VAL_W-1:0]  contiguous_read,
    output logic signed [VAL_W-1:0]  contiguous_write,
    output logic [TOT_W-1:0]         overflow_total,
    output logic [TOT_W-1:0]         underflow_total,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    cfg_t        cfg;
    logic        cfg_clear;
    cmd_t        cmd_in;
    logic        cmd_load;
    ring_state_t st;
    logic        upd_valid;

    assign busy            = 1'b0;
    assign cmd_load        = start && !busy;
    assign cmd_in.mode     = mode;
    assign cmd_in.count    = count;
    assign cmd_in.blocking = blocking;

    brpm_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg       (cfg),
        .cfg_clear (cfg_clear)
    );

    brpm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_load  (cmd_load),
        .cmd_in    (cmd_in),
        .cfg       (cfg),
        .cfg_clear (cfg_clear),
        .st        (st),
        .upd_valid (upd_valid)
    );

    brpm_result u_result (
        .clk              (clk),
        .rst_n            (rst_n),
        .upd_valid        (upd_valid),
        .st               (st),
        .cfg              (cfg),
        .done             (done),
        .write_address    (write_address),
        .read_address     (read_address),
        .free_to_read     (free_to_read),
        .free_to_write    (free_to_write),
        .contiguous_read  (contiguous_read),
        .contiguous_write (contiguous_write),
        .overflow_total   (overflow_total),
        .underflow_total  (underflow_total)
    );

endmodule
